### src/smf_pkg.sv
// Shared constants and types of the sorted median finder.
package smf_pkg;

	// Capacity of the insertion chain and width of one data value.
	localparam int MAX_ITEMS  = 64;
	localparam int VALUE_BITS = 16;

	// Result widths.
	localparam int OUT_BITS   = VALUE_BITS + 1;
	localparam int COUNT_BITS = 7;

	// Internal widths derived from the capacity.
	localparam int CNT_BITS = $clog2(MAX_ITEMS + 1);
	localparam int IDX_BITS = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

	// Middle-value pick is done in groups, one registered level per group.
	localparam int GROUP_SIZE = 8;
	localparam int NUM_GROUPS = (MAX_ITEMS + GROUP_SIZE - 1) / GROUP_SIZE;

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic signed [OUT_BITS-1:0]   median_t;
	typedef logic [CNT_BITS-1:0]          cnt_t;
	typedef logic [IDX_BITS-1:0]          idx_t;

	// What one cell shows to its right-hand neighbor.
	typedef struct packed {
		logic   occ;
		logic   gt;
		value_t val;
	} link_t;

endpackage

### src/smf_if.sv
// Handshake channels of the sorted median finder: data input and median result.
interface smf_in_if import smf_pkg::*;;
	logic   valid;
	logic   ready;
	value_t value;
	logic   last_item;

	modport source (output valid, output value, output last_item, input ready);
	modport sink (input valid, input value, input last_item, output ready);
endinterface

interface smf_out_if import smf_pkg::*;;
	logic                  valid;
	logic                  ready;
	median_t               median_doubled;
	logic [COUNT_BITS-1:0] item_count;
	logic                  overflow;

	modport source (output valid, output median_doubled, output item_count,
		output overflow, input ready);
	modport sink (input valid, input median_doubled, input item_count,
		input overflow, output ready);
endinterface

### src/sorted_median_finder.sv
// Top level of the sorted median finder: insertion chain, control and result register.
//
// The sample channel carries one signed value per word plus a last_item mark.
// Each value is inserted in ascending order into a chain of MAX_ITEMS cells,
// behind any equal values, in the cycle it is accepted; plain values are taken
// at one word per clock. A value arriving when the chain is full is dropped and
// the overflow flag of the set is raised.
// The word marked last is inserted as well, after which the block passes through
// a gather state (one registered level of group masks) and a sum state (the
// combine and add, held until the output register is free) and drops ready
// meanwhile. The result word is registered as the sum state is left.
// The result word gives twice the median (fixed point, one fraction bit), the
// number of values kept and the overflow flag. It sits in an output register:
// the next set can be streamed in while it waits, and only a second last
// word stalls until the receiver has taken the first result.
// Reset empties the chain and the overflow flag and clears the result register;
// the cell contents need no reset since only occupied cells are ever read.
module sorted_median_finder import smf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	smf_in_if.sink     sample,
	smf_out_if.source  result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GATHER,
		ST_SUM
	} state_t;

	state_t                state_q;
	cnt_t                  count_q;
	logic                  ovf_q;
	logic                  out_valid_q;
	median_t               median_q;
	logic [COUNT_BITS-1:0] out_count_q;
	logic                  out_ovf_q;

	logic    accept;
	logic    full;
	logic    insert;
	logic    out_free;
	logic    load_out;
	idx_t    lo_idx;
	idx_t    hi_idx;
	median_t mid_sum;
	link_t   links [MAX_ITEMS+1];
	value_t  vals  [MAX_ITEMS];

	// Handshake and fill state.
	assign sample.ready = (state_q == ST_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign full         = (count_q == CNT_BITS'(MAX_ITEMS));
	assign insert       = accept && !full;
	assign out_free     = !out_valid_q || result.ready;
	assign load_out     = (state_q == ST_SUM) && out_free;

	// Positions of the two middle values; equal for an odd count.
	assign lo_idx = IDX_BITS'((count_q - CNT_BITS'(1)) >> 1);
	assign hi_idx = IDX_BITS'(count_q >> 1);

	// Head of the chain: always occupied and never larger than the new value.
	assign links[0] = '{occ: 1'b1, gt: 1'b0, val: '0};

	// The insertion chain.
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		smf_cell u_cell (
			.clk     (clk),
			.insert  (insert),
			.occ     (CNT_BITS'(i) < count_q),
			.new_val (sample.value),
			.left    (links[i]),
			.right   (links[i+1])
		);
		assign vals[i] = links[i+1].val;
	end

	// Middle-value pick and sum.
	smf_mid_select u_mid (
		.clk    (clk),
		.load   (state_q == ST_GATHER),
		.vals   (vals),
		.lo_idx (lo_idx),
		.hi_idx (hi_idx),
		.sum    (mid_sum)
	);

	// Control, fill count and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			median_q    <= '0;
			out_count_q <= '0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (insert) begin
						count_q <= count_q + CNT_BITS'(1);
					end
					if (accept && full) begin
						ovf_q <= 1'b1;
					end
					if (accept && sample.last_item) begin
						state_q <= ST_GATHER;
					end
				end
				ST_GATHER: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (load_out) begin
						median_q    <= mid_sum;
						out_count_q <= COUNT_BITS'(count_q);
						out_ovf_q   <= ovf_q;
						count_q     <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid          = out_valid_q;
	assign result.median_doubled = median_q;
	assign result.item_count     = out_count_q;
	assign result.overflow       = out_ovf_q;

endmodule

### src/smf_cell.sv
// One cell of the insertion chain: holds one sorted value and shifts right on insert when the new value is smaller.
module smf_cell import smf_pkg::*; (
	input  logic   clk,
	input  logic   insert,
	input  logic   occ,
	input  value_t new_val,
	input  link_t  left,
	output link_t  right
);

	value_t val_q;
	logic   gt;
	logic   take;

	// A held value larger than the new one must make room by moving right.
	assign gt = occ && (val_q > new_val);

	// The cell changes when it moves, or when it is the first free slot.
	assign take = gt || (!occ && left.occ);

	always_ff @(posedge clk) begin
		if (insert && take) begin
			if (left.gt) begin
				val_q <= left.val;
			end else begin
				val_q <= new_val;
			end
		end
	end

	assign right.occ = occ;
	assign right.gt  = gt;
	assign right.val = val_q;

endmodule

### src/smf_mid_select.sv
// Picks the two middle values out of the chain and adds them.
module smf_mid_select import smf_pkg::*; (
	input  logic    clk,
	input  logic    load,
	input  value_t  vals [MAX_ITEMS],
	input  idx_t    lo_idx,
	input  idx_t    hi_idx,
	output median_t sum
);

	value_t lo_grp_s1 [NUM_GROUPS];
	value_t hi_grp_s1 [NUM_GROUPS];
	value_t lo_val;
	value_t hi_val;

	// First level: each group of cells is masked by index and OR-reduced.
	for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
		value_t lo_acc;
		value_t hi_acc;

		always_comb begin
			lo_acc = '0;
			hi_acc = '0;
			for (int k = 0; k < GROUP_SIZE; k++) begin
				if (g * GROUP_SIZE + k < MAX_ITEMS) begin
					if (IDX_BITS'(g * GROUP_SIZE + k) == lo_idx) begin
						lo_acc = lo_acc | vals[g * GROUP_SIZE + k];
					end
					if (IDX_BITS'(g * GROUP_SIZE + k) == hi_idx) begin
						hi_acc = hi_acc | vals[g * GROUP_SIZE + k];
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (load) begin
				lo_grp_s1[g] <= lo_acc;
				hi_grp_s1[g] <= hi_acc;
			end
		end
	end

	// Second level: combine the groups, then add the two middles.
	always_comb begin
		lo_val = '0;
		hi_val = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			lo_val = lo_val | lo_grp_s1[g];
			hi_val = hi_val | hi_grp_s1[g];
		end
	end

	assign sum = median_t'(lo_val) + median_t'(hi_val);

endmodule

### bench/tb_top.sv
// Self-checking testbench of the sorted median finder: random stalls on both channels.
`timescale 1ns / 100ps

module tb_top;
	import smf_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 20;
	localparam int TARGET_WORDS = 1800;

	typedef logic [COUNT_BITS-1:0] count_t;

	// One sample word as queued for the driver.
	typedef struct {
		value_t value;
		logic   last;
		logic   hold;
	} sample_word_t;

	// One predicted result word.
	typedef struct {
		median_t median;
		count_t  count;
		logic    ovf;
	} median_word_t;

	logic clk;
	logic arst_n;

	smf_in_if  sample_ch ();
	smf_out_if result_ch ();

	sorted_median_finder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch)
	);

	sample_word_t pending[$];
	median_word_t median_due[$];
	value_t       kept[$];
	logic         dropped;
	int           sets_closed;
	int           medians_checked;
	int           mismatches;
	int           words_sent;
	int           overflow_sets;
	int           longest_set;
	int           cycle;
	logic         steady;

	// Clock.
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// A stretch of cycles in which neither side idles.
	assign steady = (cycle >= 1000) && (cycle < 1800);

	// Watchdog and cycle count.
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $realtime, cycle);
			$display("tb_top: errors");
			$finish;
		end
	end

	// Insert one value behind any equal ones; on the last word of a set, work out
	// the doubled median and open a new set.
	task automatic absorb_sample(input value_t v, input logic last);
		int pos;
		int n;
		int lo;
		int hi;
		int twice;
		median_word_t m;
		if (kept.size() >= MAX_ITEMS) begin
			dropped = 1'b1;
		end else begin
			pos = kept.size();
			while (pos > 0 && kept[pos-1] > v)
				pos--;
			kept.insert(pos, v);
		end
		if (last) begin
			n = kept.size();
			hi = kept[n/2];
			if (n % 2 == 1) begin
				twice = 2 * hi;
			end else begin
				lo = kept[n/2 - 1];
				twice = lo + hi;
			end
			m.median = median_t'(twice);
			m.count = count_t'(n);
			m.ovf = dropped;
			median_due.push_back(m);
			if (dropped)
				overflow_sets++;
			if (n > longest_set)
				longest_set = n;
			kept.delete();
			dropped = 1'b0;
		end
	endtask

	// Driver: presents queued words, keeps a word steady until it is taken, and
	// runs the prediction on every accepted word.
	always @(posedge clk) begin : drive
		int   closed_now;
		logic offer;
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
		end else if (!sample_ch.valid || sample_ch.ready) begin
			closed_now = sets_closed;
			if (sample_ch.valid) begin
				absorb_sample(sample_ch.value, sample_ch.last_item);
				pending.pop_front();
				words_sent++;
				if (sample_ch.last_item)
					closed_now++;
				sets_closed <= closed_now;
			end
			offer = (pending.size() > 0) && (steady || $urandom_range(99) >= 36);
			// A held word waits until every outstanding median has come back.
			if (offer && pending[0].hold && closed_now != medians_checked)
				offer = 1'b0;
			sample_ch.valid <= offer;
			if (offer) begin
				sample_ch.value <= pending[0].value;
				sample_ch.last_item <= pending[0].last;
			end
		end
	end

	// Monitor: checks each taken result word against the oldest closed set not yet checked.
	always @(posedge clk) begin : watch
		median_word_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (medians_checked >= sets_closed) begin
					mismatches++;
					$display("%0t: unexpected result: median %0d count %0d overflow %0b",
						$realtime, result_ch.median_doubled, result_ch.item_count,
						result_ch.overflow);
				end else begin
					want = median_due[medians_checked];
					if (result_ch.median_doubled !== want.median) begin
						mismatches++;
						$display("%0t: median_doubled expected %0d actual %0d",
							$realtime, want.median, result_ch.median_doubled);
					end
					if (result_ch.item_count !== want.count) begin
						mismatches++;
						$display("%0t: item_count expected %0d actual %0d",
							$realtime, want.count, result_ch.item_count);
					end
					if (result_ch.overflow !== want.ovf) begin
						mismatches++;
						$display("%0t: overflow expected %0b actual %0b",
							$realtime, want.ovf, result_ch.overflow);
					end
					medians_checked <= medians_checked + 1;
				end
			end
			result_ch.ready <= steady || ($urandom_range(99) >= 36);
		end
	end

	task automatic push_word(input int v, input logic last, input logic hold);
		sample_word_t w;
		w.value = value_t'(v);
		w.last = last;
		w.hold = hold;
		pending.push_back(w);
	endtask

	// Queue one set of the given length; the flavor picks full-range values,
	// a narrow range full of duplicates, or the field extremes.
	task automatic push_set(input int len, input int flavor, input logic hold);
		int v;
		for (int i = 0; i < len; i++) begin
			case (flavor)
				0: v = $signed(value_t'($urandom));
				1: v = int'($urandom_range(15)) - 8;
				default: begin
					case ($urandom_range(4))
						0: v = -32768;
						1: v = 32767;
						2: v = -1;
						3: v = 0;
						default: v = 1;
					endcase
				end
			endcase
			push_word(v, i == len - 1, hold && i == 0);
		end
	endtask

	// Stimulus, end of run and verdict.
	initial begin
		int len;
		int queued;
		arst_n = 1'b0;
		cycle = 0;
		dropped = 1'b0;
		sets_closed = 0;
		medians_checked = 0;
		mismatches = 0;
		words_sent = 0;
		overflow_sets = 0;
		longest_set = 0;
		sample_ch.valid = 1'b0;
		sample_ch.value = '0;
		sample_ch.last_item = 1'b0;
		result_ch.ready = 1'b0;

		// Single values at both extremes.
		push_word(32767, 1'b1, 1'b0);
		push_word(-32768, 1'b1, 1'b0);
		// Even pairs of extreme values, reaching both ends of the result range.
		push_word(-32768, 1'b0, 1'b0);
		push_word(32767, 1'b1, 1'b0);
		push_word(32767, 1'b0, 1'b0);
		push_word(32767, 1'b1, 1'b0);
		push_word(-32768, 1'b0, 1'b1);
		push_word(-32768, 1'b1, 1'b0);
		// Odd set with duplicates of the middle value.
		push_word(5, 1'b0, 1'b0);
		push_word(-3, 1'b0, 1'b0);
		push_word(5, 1'b0, 1'b0);
		push_word(0, 1'b0, 1'b0);
		push_word(5, 1'b1, 1'b0);
		// Even sets whose middle sum is zero and odd.
		push_word(7, 1'b0, 1'b0);
		push_word(-7, 1'b0, 1'b0);
		push_word(1, 1'b0, 1'b0);
		push_word(-1, 1'b1, 1'b0);
		push_word(-1, 1'b0, 1'b0);
		push_word(-2, 1'b1, 1'b0);

		// Exactly full, full with the last word dropped, and a longer overflow.
		push_set(MAX_ITEMS, 0, 1'b0);
		push_set(MAX_ITEMS + 1, 1, 1'b1);
		push_set(MAX_ITEMS + 3, 2, 1'b0);

		// Random sets, mostly short, now and then at or past capacity.
		queued = pending.size();
		while (queued < TARGET_WORDS) begin
			case ($urandom_range(19))
				0: len = $urandom_range(MAX_ITEMS + 8, MAX_ITEMS);
				1, 2, 3: len = $urandom_range(MAX_ITEMS - 1, 13);
				default: len = $urandom_range(12, 1);
			endcase
			push_set(len, $urandom_range(5) < 3 ? 0 : $urandom_range(2, 1),
				$urandom_range(11) == 0);
			queued += len;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the last word to be taken and every median to come back,
		// then give the block time to show any stray result. The counters are
		// looked at between edges, once the edge's updates have settled.
		@(negedge clk);
		while (pending.size() != 0 || sets_closed != medians_checked)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);

		if (medians_checked != sets_closed) begin
			mismatches++;
			$display("%0t: result count expected %0d actual %0d",
				$realtime, sets_closed, medians_checked);
		end

		$display("Sent %0d sample words in %0d sets; %0d sets hit the capacity limit.",
			words_sent, sets_closed, overflow_sets);
		$display("Checked %0d medians, largest set kept %0d values, %0d mismatches.",
			medians_checked, longest_set, mismatches);
		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

### sorted_median_finder.f
src/smf_pkg.sv
src/smf_if.sv
src/smf_cell.sv
src/smf_mid_select.sv
src/sorted_median_finder.sv
bench/tb_top.sv
